/* sv/bsf_pkg.sv */
// Shared types and constants for the byte stuffing framer.
// Used by byte_stuffing_framer_unit; no other dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

	localparam logic [7:0] BOT_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h20;
	localparam logic [7:0] EOT_BYTE = 8'h7F;

	// Most results one item can cause.
	localparam int unsigned MAX_RUN = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       frame_end;
		logic       direction;
		logic       frame_error;
	} bsf_entry_t;

	function automatic bsf_entry_t make_entry(input logic [7:0] data, input logic bv,
			input logic fend, input logic dir, input logic err);
		bsf_entry_t e;
		e.data        = bv ? data : 8'h00;
		e.byte_valid  = bv;
		e.frame_end   = fend;
		e.direction   = dir;
		e.frame_error = err;
		return e;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == ESC_BYTE) || (b == BOT_BYTE) || (b == EOT_BYTE);
	endfunction

endpackage

/* sv/byte_stuffing_framer_unit.sv */
// Byte stuffing framer / deframer top level.
// Depends on bsf_pkg (constants, result entry type).
`timescale 1ns / 1ps

// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+---------------------------------------------
// input    | in_valid   | in_stall   | in_byte, frame_last
// output   | out_valid  | out_stall  | out_byte, byte_valid, run_last, frame_end,
//          |            |            | direction, frame_error
//
// An item is registered, then turned into a run of 0 to 4 results that is loaded
// into the run buffer; the buffer sends one result per cycle unless out_stall is
// high. The next item is loaded in the cycle the last result of the run leaves.
// Reset clears frame state and both valid flags; stalls hold the current result.

module byte_stuffing_framer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       frame_end,
	output logic       direction,
	output logic       frame_error
);

	localparam int unsigned IW = $clog2(bsf_pkg::MAX_RUN);
	localparam int unsigned CW = $clog2(bsf_pkg::MAX_RUN + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// frame state
	logic       in_frame_q;
	logic       deframe_q;
	logic       esc_q;
	logic       hold_valid_q;
	logic [7:0] hold_byte_q;

	logic       in_frame_d;
	logic       deframe_d;
	logic       esc_d;
	logic       hold_valid_d;
	logic [7:0] hold_byte_d;

	// run buffer
	bsf_pkg::bsf_entry_t run_q [bsf_pkg::MAX_RUN];
	bsf_pkg::bsf_entry_t run_d [bsf_pkg::MAX_RUN];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [IW-1:0] idx_q;

	logic at_end;
	logic buf_free;
	logic load;

	assign at_end   = ({1'b0, idx_q} == (cnt_q - CW'(1)));
	assign buf_free = (cnt_q == '0) || (at_end && !out_stall);
	assign load     = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	always_comb begin
		logic [7:0] b;
		b            = byte_s1;
		cnt_d        = '0;
		in_frame_d   = in_frame_q;
		deframe_d    = deframe_q;
		esc_d        = esc_q;
		hold_valid_d = hold_valid_q;
		hold_byte_d  = hold_byte_q;
		for (int i = 0; i < int'(bsf_pkg::MAX_RUN); i++) begin
			run_d[i] = bsf_pkg::make_entry(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		end

		if (!in_frame_q && (b == bsf_pkg::BOT_BYTE)) begin
			if (last_s1) begin
				// lone start byte: error end marker
				run_d[0] = bsf_pkg::make_entry(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
				cnt_d    = CW'(1);
			end else begin
				in_frame_d   = 1'b1;
				deframe_d    = 1'b1;
				esc_d        = 1'b0;
				hold_valid_d = 1'b0;
				hold_byte_d  = 8'h00;
			end
		end else if (!in_frame_q || !deframe_q) begin
			// framing
			if (!in_frame_q) begin
				run_d[cnt_d[IW-1:0]] = bsf_pkg::make_entry(bsf_pkg::BOT_BYTE,
						1'b1, 1'b0, 1'b0, 1'b0);
				cnt_d = cnt_d + CW'(1);
			end
			if (bsf_pkg::needs_escape(b)) begin
				run_d[cnt_d[IW-1:0]] = bsf_pkg::make_entry(bsf_pkg::ESC_BYTE,
						1'b1, 1'b0, 1'b0, 1'b0);
				cnt_d = cnt_d + CW'(1);
				run_d[cnt_d[IW-1:0]] = bsf_pkg::make_entry(b ^ bsf_pkg::ESC_BYTE,
						1'b1, 1'b0, 1'b0, 1'b0);
				cnt_d = cnt_d + CW'(1);
			end else begin
				run_d[cnt_d[IW-1:0]] = bsf_pkg::make_entry(b, 1'b1, 1'b0, 1'b0, 1'b0);
				cnt_d = cnt_d + CW'(1);
			end
			if (last_s1) begin
				run_d[cnt_d[IW-1:0]] = bsf_pkg::make_entry(bsf_pkg::EOT_BYTE,
						1'b1, 1'b1, 1'b0, 1'b0);
				cnt_d      = cnt_d + CW'(1);
				in_frame_d = 1'b0;
			end else begin
				in_frame_d = 1'b1;
			end
			deframe_d = 1'b0;
		end else if (last_s1) begin
			// final deframe byte is dropped; flush the hold or send an end marker
			run_d[0] = bsf_pkg::make_entry(hold_byte_q, hold_valid_q, 1'b1, 1'b1, 1'b0);
			cnt_d        = CW'(1);
			in_frame_d   = 1'b0;
			deframe_d    = 1'b0;
			esc_d        = 1'b0;
			hold_valid_d = 1'b0;
			hold_byte_d  = 8'h00;
		end else if (!esc_q && (b == bsf_pkg::ESC_BYTE)) begin
			esc_d = 1'b1;
		end else begin
			if (hold_valid_q) begin
				run_d[0] = bsf_pkg::make_entry(hold_byte_q, 1'b1, 1'b0, 1'b1, 1'b0);
				cnt_d    = CW'(1);
			end
			hold_byte_d  = esc_q ? (b ^ bsf_pkg::ESC_BYTE) : b;
			hold_valid_d = 1'b1;
			esc_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			deframe_q    <= 1'b0;
			esc_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_byte_q  <= 8'h00;
		end else if (load) begin
			in_frame_q   <= in_frame_d;
			deframe_q    <= deframe_d;
			esc_q        <= esc_d;
			hold_valid_q <= hold_valid_d;
			hold_byte_q  <= hold_byte_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_d;
			idx_q <= '0;
		end else if ((cnt_q != '0) && !out_stall) begin
			if (at_end) begin
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < int'(bsf_pkg::MAX_RUN); i++) begin
				run_q[i] <= run_d[i];
			end
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign out_byte    = run_q[idx_q].data;
	assign byte_valid  = run_q[idx_q].byte_valid;
	assign frame_end   = run_q[idx_q].frame_end;
	assign direction   = run_q[idx_q].direction;
	assign frame_error = run_q[idx_q].frame_error;
	assign run_last    = at_end;

endmodule
